### sv/eslc_pkg.sv
package eslc_pkg;

  // Cache geometry
  localparam int SLOTS     = 18;
  localparam int LAYERS    = 64;
  localparam int EXPERTS   = 128;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAP_DEPTH = LAYERS * EXPERTS;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  // Fixed field widths
  localparam int LAYER_W    = 6;
  localparam int EXPERT_W   = 7;
  localparam int COUNT_W    = 8;
  localparam int STAMP_W    = 64;
  localparam int CNT_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 5;
  localparam int CFG_W      = 64;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [SLOT_OUT_W-1:0] slot_out_t;
  typedef logic [MAP_AW-1:0]     map_addr_t;
  typedef logic [LAYER_W-1:0]    layer_t;
  typedef logic [EXPERT_W-1:0]   expert_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [STAMP_W-1:0]    stamp_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Configuration register indexes
  localparam logic [0:0] REG_LAYER_MASK   = 1'b0;
  localparam logic [0:0] REG_EXPERT_COUNT = 1'b1;

  localparam count_t EXPERT_COUNT_RESET = count_t'(128);

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    RES_HIT        = 3'd0,
    RES_MISS       = 3'd1,
    RES_BAD_LAYER  = 3'd2,
    RES_BAD_EXPERT = 3'd3,
    RES_ABSENT     = 3'd4
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_SCAN,
    ST_FILL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture item, launch map read
    logic hit_upd;  // restamp hit slot, count hit
    logic scan_en;  // one step of the victim search
    logic fill;     // retag victim, write map, count miss
    logic post;     // register the result
    res_t res;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad_layer;
    logic bad_expert;
    logic held;
    logic lookup;
    logic scan_last;
  } stat_t;

  function automatic map_addr_t map_index(layer_t l, expert_t e);
    return map_addr_t'(int'(l) * EXPERTS + int'(e));
  endfunction

endpackage

### sv/expert_slot_lru_cache_core.sv
// Flow: an accepted item is probed against the reverse map; hits, lookups
// and bad items post their result from the probe; a request that misses first
// runs the victim search over one stamp a cycle, then fills the victim.
// One item at a time: busy is high from accept until the result is registered.
// Reset: synchronous, active high; clears slots, counters and config with no
// clearing pass, as map entries are checked against the slot tags on read.
module expert_slot_lru_cache_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [eslc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            opcode,
  input  eslc_pkg::layer_t                layer,
  input  eslc_pkg::expert_t               expert,
  input  logic                            last_in_group,
  output logic                            done,
  output logic [eslc_pkg::STATUS_W-1:0]   status,
  output eslc_pkg::slot_out_t             slot,
  output logic                            evicted_valid,
  output eslc_pkg::layer_t                evicted_layer,
  output eslc_pkg::expert_t               evicted_expert,
  output eslc_pkg::cnt_t                  hit_total,
  output eslc_pkg::cnt_t                  miss_total,
  output logic                            group_end
);

  eslc_pkg::cmd_t  cmd;
  eslc_pkg::stat_t stat;

  eslc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  eslc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .layer          (layer),
    .expert         (expert),
    .last_in_group  (last_in_group),
    .status         (status),
    .slot           (slot),
    .evicted_valid  (evicted_valid),
    .evicted_layer  (evicted_layer),
    .evicted_expert (evicted_expert),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .group_end      (group_end),
    .done           (done)
  );

endmodule

### sv/eslc_ram.sv
module eslc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           re,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/eslc_ctrl.sv
module eslc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  eslc_pkg::stat_t stat,
  output eslc_pkg::cmd_t  cmd,
  output logic            busy
);

  eslc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eslc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      eslc_pkg::ST_IDLE: begin
        if (start) state_next = eslc_pkg::ST_PROBE;
      end
      eslc_pkg::ST_PROBE: begin
        if (stat.bad_layer || stat.bad_expert || stat.held || stat.lookup) begin
          state_next = eslc_pkg::ST_IDLE;
        end else begin
          state_next = eslc_pkg::ST_SCAN;
        end
      end
      eslc_pkg::ST_SCAN: begin
        if (stat.scan_last) state_next = eslc_pkg::ST_FILL;
      end
      eslc_pkg::ST_FILL: begin
        state_next = eslc_pkg::ST_IDLE;
      end
      default: state_next = eslc_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd     = '0;
    cmd.res = eslc_pkg::RES_HIT;
    busy    = 1'b1;
    case (state)
      eslc_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      eslc_pkg::ST_PROBE: begin
        if (stat.bad_layer) begin
          cmd.post = 1'b1;
          cmd.res  = eslc_pkg::RES_BAD_LAYER;
        end else if (stat.bad_expert) begin
          cmd.post = 1'b1;
          cmd.res  = eslc_pkg::RES_BAD_EXPERT;
        end else if (stat.held) begin
          cmd.post    = 1'b1;
          cmd.res     = eslc_pkg::RES_HIT;
          cmd.hit_upd = !stat.lookup;
        end else if (stat.lookup) begin
          cmd.post = 1'b1;
          cmd.res  = eslc_pkg::RES_ABSENT;
        end
      end
      eslc_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      eslc_pkg::ST_FILL: begin
        cmd.fill = 1'b1;
        cmd.post = 1'b1;
        cmd.res  = eslc_pkg::RES_MISS;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### sv/eslc_dp.sv
module eslc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  eslc_pkg::cmd_t                      cmd,
  output eslc_pkg::stat_t                     stat,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [eslc_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                opcode,
  input  eslc_pkg::layer_t                    layer,
  input  eslc_pkg::expert_t                   expert,
  input  logic                                last_in_group,
  output logic [eslc_pkg::STATUS_W-1:0]       status,
  output eslc_pkg::slot_out_t                 slot,
  output logic                                evicted_valid,
  output eslc_pkg::layer_t                    evicted_layer,
  output eslc_pkg::expert_t                   evicted_expert,
  output eslc_pkg::cnt_t                      hit_total,
  output eslc_pkg::cnt_t                      miss_total,
  output logic                                group_end,
  output logic                                done
);

  // Configuration
  logic [eslc_pkg::CFG_W-1:0] layer_valid_mask;
  eslc_pkg::count_t           expert_count;

  // Captured item
  logic                 op_q;
  eslc_pkg::layer_t     layer_q;
  eslc_pkg::expert_t    expert_q;
  logic                 last_q;
  logic                 bad_layer_q;
  logic                 bad_expert_q;
  eslc_pkg::map_addr_t  idx_q;

  // Slot state
  logic                 slot_valid  [eslc_pkg::SLOTS];
  eslc_pkg::layer_t     tag_layer   [eslc_pkg::SLOTS];
  eslc_pkg::expert_t    tag_expert  [eslc_pkg::SLOTS];
  eslc_pkg::stamp_t     slot_stamp  [eslc_pkg::SLOTS];
  eslc_pkg::stamp_t     use_counter;
  eslc_pkg::cnt_t       hit_counter;
  eslc_pkg::cnt_t       miss_counter;

  // Victim search
  eslc_pkg::slot_t      scan_idx;
  eslc_pkg::slot_t      best_idx;
  eslc_pkg::stamp_t     best_stamp;
  eslc_pkg::stamp_t     scan_stamp;

  // Map memory and slot read port
  eslc_pkg::slot_t      map_rdata;
  eslc_pkg::slot_t      rd_slot;
  logic                 rd_in;
  logic                 rd_valid;
  eslc_pkg::layer_t     rd_layer;
  eslc_pkg::expert_t    rd_expert;
  eslc_pkg::stamp_t     use_next;

  // Result registers
  eslc_pkg::res_t       res_q;
  eslc_pkg::slot_out_t  slot_q;
  logic                 ev_valid_q;
  eslc_pkg::layer_t     ev_layer_q;
  eslc_pkg::expert_t    ev_expert_q;
  logic                 group_end_q;
  logic                 done_q;

  // Reverse map: entry is trusted only if its slot still carries the tag
  eslc_ram #(
    .WIDTH (eslc_pkg::SLOT_W),
    .DEPTH (eslc_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (cmd.fill),
    .waddr (idx_q),
    .wdata (best_idx),
    .re    (cmd.load),
    .raddr (eslc_pkg::map_index(layer, expert)),
    .rdata (map_rdata)
  );

  // Single slot read port: map hit slot while probing, victim while filling
  always_comb begin
    rd_slot   = cmd.fill ? best_idx : map_rdata;
    rd_in     = int'(rd_slot) < eslc_pkg::SLOTS;
    rd_valid  = 1'b0;
    rd_layer  = '0;
    rd_expert = '0;
    if (rd_in) begin
      rd_valid  = slot_valid[rd_slot];
      rd_layer  = tag_layer[rd_slot];
      rd_expert = tag_expert[rd_slot];
    end
  end

  always_comb begin
    scan_stamp = '0;
    if (int'(scan_idx) < eslc_pkg::SLOTS) scan_stamp = slot_stamp[scan_idx];
  end

  assign use_next = use_counter + eslc_pkg::stamp_t'(1);

  // Status to controller
  always_comb begin
    stat.bad_layer  = bad_layer_q;
    stat.bad_expert = bad_expert_q;
    stat.held       = rd_valid && (rd_layer == layer_q) && (rd_expert == expert_q);
    stat.lookup     = op_q;
    stat.scan_last  = scan_idx == eslc_pkg::slot_t'(eslc_pkg::SLOTS - 1);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_valid_mask <= '0;
      expert_count     <= eslc_pkg::EXPERT_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        eslc_pkg::REG_LAYER_MASK:   layer_valid_mask <= cfg_data;
        eslc_pkg::REG_EXPERT_COUNT: expert_count     <= cfg_data[eslc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture with range checks
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q         <= opcode;
      layer_q      <= layer;
      expert_q     <= expert;
      last_q       <= last_in_group;
      idx_q        <= eslc_pkg::map_index(layer, expert);
      bad_layer_q  <= (int'(layer) >= eslc_pkg::LAYERS) || !layer_valid_mask[layer];
      bad_expert_q <= ({1'b0, expert} >= expert_count) ||
                      (int'(expert) >= eslc_pkg::EXPERTS);
    end
  end

  // Victim search: oldest stamp, lowest index on ties
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx <= '0;
    end else if (cmd.scan_en) begin
      scan_idx <= scan_idx + eslc_pkg::slot_t'(1);
      if (scan_idx == '0 || scan_stamp < best_stamp) begin
        best_idx   <= scan_idx;
        best_stamp <= scan_stamp;
      end
    end
  end

  // Slot state, stamps and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < eslc_pkg::SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_stamp[i] <= '0;
      end
      use_counter  <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else begin
      if (cmd.hit_upd) begin
        slot_stamp[map_rdata] <= use_next;
        use_counter           <= use_next;
        if (hit_counter != '1) hit_counter <= hit_counter + eslc_pkg::cnt_t'(1);
      end
      if (cmd.fill) begin
        slot_valid[best_idx] <= 1'b1;
        slot_stamp[best_idx] <= use_next;
        use_counter          <= use_next;
        if (miss_counter != '1) miss_counter <= miss_counter + eslc_pkg::cnt_t'(1);
      end
    end
  end

  // Tags carry no reset: read only behind a valid bit
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      tag_layer[best_idx]  <= layer_q;
      tag_expert[best_idx] <= expert_q;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.post) begin
      res_q       <= cmd.res;
      group_end_q <= last_q;
      case (cmd.res)
        eslc_pkg::RES_HIT:  slot_q <= eslc_pkg::slot_out_t'(map_rdata);
        eslc_pkg::RES_MISS: slot_q <= eslc_pkg::slot_out_t'(best_idx);
        default:            slot_q <= '0;
      endcase
      if (cmd.fill && rd_valid) begin
        ev_valid_q  <= 1'b1;
        ev_layer_q  <= rd_layer;
        ev_expert_q <= rd_expert;
      end else begin
        ev_valid_q  <= 1'b0;
        ev_layer_q  <= '0;
        ev_expert_q <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd.post;
    end
  end

  assign status         = res_q;
  assign slot           = slot_q;
  assign evicted_valid  = ev_valid_q;
  assign evicted_layer  = ev_layer_q;
  assign evicted_expert = ev_expert_q;
  assign hit_total      = hit_counter;
  assign miss_total     = miss_counter;
  assign group_end      = group_end_q;
  assign done           = done_q;

  // A filled slot is marked valid afterwards
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |=> slot_valid[$past(best_idx)])
    else $error("victim slot not valid after fill");

  // A miss always names an existing slot
  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    (done_q && res_q == eslc_pkg::RES_MISS) |-> (int'(slot_q) < eslc_pkg::SLOTS))
    else $error("miss reports slot out of range");

  // Eviction is reported only with a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (done_q && ev_valid_q) |-> (res_q == eslc_pkg::RES_MISS))
    else $error("eviction without miss");

  // Hit and miss counts never move together and never fall
  a_count_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.hit_upd && cmd.fill))
    else $error("hit and miss update in one cycle");

  a_hit_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (hit_counter >= $past(hit_counter)))
    else $error("hit count decreased");

endmodule

### bench/eslc_cache_checker.sv
package eslc_tb_pkg;
  import eslc_pkg::*;

  // Item opcodes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_LOOKUP  = 1'b1;

  // One result item as the block should present it
  typedef struct packed {
    res_t      status;
    slot_out_t slot;
    logic      ev_valid;
    layer_t    ev_layer;
    expert_t   ev_expert;
    cnt_t      hits;
    cnt_t      misses;
    logic      grp_end;
  } cache_result_t;
endpackage

module eslc_cache_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [eslc_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          opcode,
  input  eslc_pkg::layer_t              layer,
  input  eslc_pkg::expert_t             expert,
  input  logic                          last_in_group,
  input  logic                          done,
  input  logic [eslc_pkg::STATUS_W-1:0] status,
  input  eslc_pkg::slot_out_t           slot,
  input  logic                          evicted_valid,
  input  eslc_pkg::layer_t              evicted_layer,
  input  eslc_pkg::expert_t             evicted_expert,
  input  eslc_pkg::cnt_t                hit_total,
  input  eslc_pkg::cnt_t                miss_total,
  input  logic                          group_end,
  output int                            errors,
  output int                            pending,
  output int                            hits_seen,
  output int                            misses_seen,
  output int                            evictions_seen,
  output int                            rejects_seen,
  output int                            absent_seen
);
  import eslc_pkg::*;
  import eslc_tb_pkg::*;

  localparam int MAX_PRINTS = 50;

  // Shadow configuration
  logic [CFG_W-1:0] mask_q;
  count_t           count_q;

  // Shadow cache: slot tags, stamps and the reverse map
  logic    tag_valid  [SLOTS];
  layer_t  tag_layer  [SLOTS];
  expert_t tag_expert [SLOTS];
  stamp_t  stamps     [SLOTS];
  stamp_t  use_ctr;
  logic    held       [MAP_DEPTH];
  slot_t   where_held [MAP_DEPTH];
  cnt_t    hit_ctr;
  cnt_t    miss_ctr;

  cache_result_t pending_results [$];
  int            checked;

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] cache check: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                           checked, name, got, want));
  endtask

  task automatic clear_state();
    mask_q   = '0;
    count_q  = EXPERT_COUNT_RESET;
    use_ctr  = '0;
    hit_ctr  = '0;
    miss_ctr = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tag_valid[i]  = 1'b0;
      tag_layer[i]  = '0;
      tag_expert[i] = '0;
      stamps[i]     = '0;
    end
    for (int i = 0; i < MAP_DEPTH; i++) begin
      held[i]       = 1'b0;
      where_held[i] = '0;
    end
    pending_results.delete();
  endtask

  // Serve one item against the shadow cache and return its result
  function automatic cache_result_t cache_access(logic op, layer_t ly, expert_t ex,
                                                 logic last);
    cache_result_t r;
    int            idx;
    int            old_idx;
    slot_t         v;
    r         = '0;
    r.status  = RES_HIT;
    r.grp_end = last;
    if (!mask_q[ly]) begin
      r.status = RES_BAD_LAYER;
    end else if (int'(ex) >= int'(count_q)) begin
      r.status = RES_BAD_EXPERT;
    end else begin
      idx = int'(ly) * EXPERTS + int'(ex);
      if (held[idx]) begin
        r.slot = slot_out_t'(where_held[idx]);
        // only a request refreshes the stamp
        if (op == OP_REQUEST) begin
          use_ctr++;
          stamps[where_held[idx]] = use_ctr;
          if (hit_ctr != '1) hit_ctr++;
        end
      end else if (op == OP_LOOKUP) begin
        r.status = RES_ABSENT;
      end else begin
        // victim: oldest stamp, lowest slot on ties
        v = '0;
        for (int i = 1; i < SLOTS; i++)
          if (stamps[i] < stamps[v]) v = slot_t'(i);
        r.status = RES_MISS;
        r.slot   = slot_out_t'(v);
        if (miss_ctr != '1) miss_ctr++;
        if (tag_valid[v]) begin
          r.ev_valid  = 1'b1;
          r.ev_layer  = tag_layer[v];
          r.ev_expert = tag_expert[v];
          old_idx = int'(tag_layer[v]) * EXPERTS + int'(tag_expert[v]);
          held[old_idx] = 1'b0;
        end
        tag_valid[v]  = 1'b1;
        tag_layer[v]  = ly;
        tag_expert[v] = ex;
        use_ctr++;
        stamps[v]       = use_ctr;
        held[idx]       = 1'b1;
        where_held[idx] = v;
      end
    end
    r.hits   = hit_ctr;
    r.misses = miss_ctr;
    return r;
  endfunction

  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      clear_state();
    end else begin
      // results first: an item accepted at this edge cannot finish here
      if (done) begin
        if (pending_results.size() == 0) begin
          flag_error("result with no item outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("status", status, want.status);
          check_field("slot", slot, want.slot);
          check_field("evicted_valid", evicted_valid, want.ev_valid);
          check_field("evicted_layer", evicted_layer, want.ev_layer);
          check_field("evicted_expert", evicted_expert, want.ev_expert);
          check_field("hit_total", hit_total, want.hits);
          check_field("miss_total", miss_total, want.misses);
          check_field("group_end", group_end, want.grp_end);
          checked++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_LAYER_MASK) mask_q = cfg_data;
        else if (cfg_index == REG_EXPERT_COUNT) count_q = count_t'(cfg_data);
      end
      if (start && !busy) begin
        want = cache_access(opcode, layer, expert, last_in_group);
        pending_results.push_back(want);
        case (want.status)
          RES_HIT:  hits_seen++;
          RES_MISS: begin
            misses_seen++;
            if (want.ev_valid) evictions_seen++;
          end
          RES_ABSENT: absent_seen++;
          default:  rejects_seen++;
        endcase
      end
    end
    pending = pending_results.size();
  end

endmodule

### bench/expert_slot_lru_cache_core_tb.sv
module expert_slot_lru_cache_core_tb;
  import eslc_pkg::*;
  import eslc_tb_pkg::*;

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 115;
  localparam int POOL_MAX      = 32;

  // Block inputs, all known from time zero
  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             start         = 1'b0;
  logic             cfg_we        = 1'b0;
  logic [0:0]       cfg_index     = '0;
  logic [CFG_W-1:0] cfg_data      = '0;
  logic             opcode        = 1'b0;
  layer_t           layer         = '0;
  expert_t          expert        = '0;
  logic             last_in_group = 1'b0;

  // Block outputs
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  slot_out_t           slot;
  logic                evicted_valid;
  layer_t              evicted_layer;
  expert_t             evicted_expert;
  cnt_t                hit_total;
  cnt_t                miss_total;
  logic                group_end;

  // From the checker
  int errors;
  int pending;
  int hits_seen;
  int misses_seen;
  int evictions_seen;
  int rejects_seen;
  int absent_seen;

  // Stimulus state
  int               items_sent = 0;
  int               phases     = 0;
  bit               burst      = 1'b0;
  logic [CFG_W-1:0] cur_mask   = '0;
  count_t           cur_count  = EXPERT_COUNT_RESET;
  layer_t           pool_layer  [POOL_MAX];
  expert_t          pool_expert [POOL_MAX];
  int               pool_size  = 1;

  always #6 clk = ~clk;

  expert_slot_lru_cache_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .layer          (layer),
    .expert         (expert),
    .last_in_group  (last_in_group),
    .done           (done),
    .status         (status),
    .slot           (slot),
    .evicted_valid  (evicted_valid),
    .evicted_layer  (evicted_layer),
    .evicted_expert (evicted_expert),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .group_end      (group_end)
  );

  eslc_cache_checker cache_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .layer          (layer),
    .expert         (expert),
    .last_in_group  (last_in_group),
    .done           (done),
    .status         (status),
    .slot           (slot),
    .evicted_valid  (evicted_valid),
    .evicted_layer  (evicted_layer),
    .evicted_expert (evicted_expert),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .group_end      (group_end),
    .errors         (errors),
    .pending        (pending),
    .hits_seen      (hits_seen),
    .misses_seen    (misses_seen),
    .evictions_seen (evictions_seen),
    .rejects_seen   (rejects_seen),
    .absent_seen    (absent_seen)
  );

  // Gap after an item: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a rising edge; returns at a rising edge
  task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_W-1:0] m, count_t c);
    write_reg(REG_LAYER_MASK, m);
    write_reg(REG_EXPERT_COUNT, CFG_W'(c));
    cur_mask  = m;
    cur_count = c;
    phases++;
  endtask

  // Present one item and hold it until accepted; start stays high across a zero gap
  task automatic send_item(logic op, layer_t ly, expert_t ex, logic last);
    int gap;
    gap = pick_gap();
    start         <= 1'b1;
    opcode        <= op;
    layer         <= ly;
    expert        <= ex;
    last_in_group <= last;
    do @(posedge clk); while (busy);
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let every outstanding item finish before touching the registers
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Working set for a phase: valid layers (any if none is valid), in-range experts
  task automatic build_pool();
    int     span;
    layer_t ly;
    span      = (cur_count == 0 || int'(cur_count) > EXPERTS) ? EXPERTS : int'(cur_count);
    pool_size = $urandom_range(10, 30);
    for (int k = 0; k < pool_size; k++) begin
      ly = layer_t'($urandom_range(0, LAYERS - 1));
      while (cur_mask != '0 && !cur_mask[ly]) ly = layer_t'($urandom_range(0, LAYERS - 1));
      pool_layer[k]  = ly;
      pool_expert[k] = expert_t'($urandom_range(0, span - 1));
    end
  endtask

  task automatic random_item();
    int      k;
    logic    op;
    layer_t  ly;
    expert_t ex;
    op = ($urandom_range(0, 3) == 0) ? OP_LOOKUP : OP_REQUEST;
    if ($urandom_range(0, 9) < 8) begin
      k  = $urandom_range(0, pool_size - 1);
      ly = pool_layer[k];
      ex = pool_expert[k];
    end else begin
      ly = layer_t'($urandom);
      ex = expert_t'($urandom);
    end
    send_item(op, ly, ex, $urandom_range(0, 3) == 0);
  endtask

  // Stimulus
  initial begin
    logic [CFG_W-1:0] m;
    count_t           c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // straight out of reset no layer is valid
    send_item(OP_REQUEST, 6'd0, 7'd0, 1'b0);
    send_item(OP_LOOKUP, 6'd63, 7'd127, 1'b1);
    drain();

    // all layers, full expert range: fills, hits, lookups, absent experts
    set_config('1, 8'd128);
    send_item(OP_REQUEST, 6'd63, 7'd127, 1'b0);
    send_item(OP_REQUEST, 6'd63, 7'd127, 1'b0);
    send_item(OP_LOOKUP, 6'd63, 7'd127, 1'b0);
    send_item(OP_LOOKUP, 6'd0, 7'd0, 1'b0);
    send_item(OP_REQUEST, 6'd0, 7'd0, 1'b1);
    send_item(OP_REQUEST, 6'd0, 7'd127, 1'b0);
    send_item(OP_REQUEST, 6'd63, 7'd0, 1'b0);
    send_item(OP_LOOKUP, 6'd42, 7'd85, 1'b0);
    send_item(OP_REQUEST, 6'd21, 7'd42, 1'b1);
    drain();

    // zero expert count rejects even held experts
    write_reg(REG_EXPERT_COUNT, CFG_W'(0));
    send_item(OP_REQUEST, 6'd0, 7'd0, 1'b0);
    send_item(OP_LOOKUP, 6'd63, 7'd127, 1'b1);
    drain();

    // only the low byte of the count register is kept
    write_reg(REG_EXPERT_COUNT, 64'hFFFF_FFFF_FFFF_FF01);
    send_item(OP_REQUEST, 6'd0, 7'd0, 1'b0);
    send_item(OP_REQUEST, 6'd0, 7'd1, 1'b0);
    send_item(OP_LOOKUP, 6'd63, 7'd0, 1'b1);
    drain();

    // edge layers only, count above the expert range
    set_config(64'h8000_0000_0000_0001, 8'd255);
    send_item(OP_REQUEST, 6'd63, 7'd127, 1'b0);
    send_item(OP_REQUEST, 6'd62, 7'd5, 1'b0);
    send_item(OP_LOOKUP, 6'd1, 7'd0, 1'b0);
    send_item(OP_REQUEST, 6'd0, 7'd127, 1'b1);
    drain();

    // random phases, each with its own settings and working set
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 5)
        0: begin
          m = '1;
          c = 8'd128;
        end
        1: begin
          m = {$urandom, $urandom};
          c = count_t'($urandom_range(1, 128));
        end
        2: begin
          m = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
          c = count_t'($urandom_range(2, 8));
        end
        3: begin
          m = '1;
          c = (p == 3) ? 8'd255 : count_t'($urandom_range(100, 128));
        end
        default: begin
          m = {$urandom, $urandom};
          c = 8'd1;
        end
      endcase
      set_config(m, c);
      build_pool();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        random_item();
      end
      drain();
    end

    // catch any stray result
    repeat (25) @(posedge clk);
    $display("summary: %0d items over %0d settings; %0d hits, %0d misses (%0d evicting)",
             items_sent, phases, hits_seen, misses_seen, evictions_seen);
    $display("summary: %0d rejected for layer or expert range, %0d lookups found nothing",
             rejects_seen, absent_seen);
    if (errors == 0) begin
      $display("expert_slot_lru_cache_core_tb: done, clean");
    end else begin
      $display("expert_slot_lru_cache_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("expert_slot_lru_cache_core_tb: done, errors");
    $finish;
  end

endmodule
